[rtl/sha256_pkg.sv]
package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned MsgWords = 16;
    localparam int unsigned ChainWords = 8;
    localparam int unsigned ByteCntW = 61;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    localparam logic [1:0] ModeAbsorb = 2'd0;
    localparam logic [1:0] ModeAbsorbFinish = 2'd1;
    localparam logic [1:0] ModeFinish = 2'd2;
    localparam logic [1:0] ModeUnused = 2'd3;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_WAIT,
        S_LOAD,
        S_ROUND,
        S_WB
    } t_state;

    function automatic t_word ror(input t_word x, input int unsigned n);
        ror = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word big_sig0(input t_word x);
        big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic t_word small_sig0(input t_word x);
        small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word init_hash(input logic [2:0] idx);
        case (idx)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

[rtl/sha256_ram.sv]
module sha256_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sha256_stream_hasher.sv]
// Each accepted byte is written into the block; a byte that fills a block starts a compression
// (chain reads, 64 rounds, chain write-back, one round per cycle).
// Finish: padding goes out one byte a cycle, held while a block that it fills is compressed;
// one or two compressions follow, and the final one waits while an earlier digest is held.
// No new byte is taken while padding or a compression is in progress.
// Reset (i_rst_n low, synchronous) clears the control state and marks the chain memory as
// holding the initial hash; no clearing pass is needed.
module sha256_stream_hasher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]   i_s_tuser,   // [1:0] mode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [255:0] o_m_tdata    // digest_word0, digest_word1, digest_word2, digest_word3
);
    import sha256_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic [5:0]  r_cnt, n_cnt;
    logic [5:0]  r_fill, n_fill;
    logic [23:0] r_acc, n_acc;
    logic [ByteCntW-1:0] r_bcnt, n_bcnt;
    logic        r_fin, n_fin;
    logic        r_fresh, n_fresh;
    logic        r_ovalid, n_ovalid;
    logic [255:0] r_out, n_out;
    t_word r_v [ChainWords];
    t_word n_v [ChainWords];
    t_word r_w [MsgWords];
    t_word n_w [MsgWords];

    logic        mw_en, cw_en;
    logic [3:0]  mr_addr;
    logic [2:0]  cr_addr, cw_addr, c_idx;
    t_word       mw_data, mr_data, cw_data, cr_data, chain_rd;
    logic        push;
    logic [7:0]  push_b;
    logic [63:0] bit_len;
    t_word       w_new, w_cur, t1, t2;
    logic        accept;

    sha256_ram #(.Width(WordW), .Depth(MsgWords)) u_msg (
        .i_clk(i_clk), .i_we(mw_en), .i_waddr(r_fill[5:2]), .i_wdata(mw_data),
        .i_raddr(mr_addr), .o_rdata(mr_data)
    );

    sha256_ram #(.Width(WordW), .Depth(ChainWords)) u_chain (
        .i_clk(i_clk), .i_we(cw_en), .i_waddr(cw_addr), .i_wdata(cw_data),
        .i_raddr(cr_addr), .o_rdata(cr_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

    assign bit_len  = {r_bcnt, 3'b000};
    assign c_idx    = r_cnt[2:0] - 3'd1;
    assign chain_rd = r_fresh ? init_hash(c_idx) : cr_data;
    assign w_new    = small_sig1(r_w[14]) + r_w[9] + small_sig0(r_w[1]) + r_w[0];
    assign w_cur    = (r_cnt[5:4] == 2'b00) ? mr_data : w_new;
    assign t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + round_k(r_cnt) + w_cur;
    assign t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cnt    = r_cnt;
        n_fill   = r_fill;
        n_acc    = r_acc;
        n_bcnt   = r_bcnt;
        n_fin    = r_fin;
        n_fresh  = r_fresh;
        n_ovalid = r_ovalid && !i_m_tready;
        n_out    = r_out;
        n_v      = r_v;
        n_w      = r_w;
        push     = 1'b0;
        push_b   = 8'h00;
        mw_en    = 1'b0;
        mr_addr  = 4'd0;
        cw_en    = 1'b0;
        cw_addr  = c_idx;
        cw_data  = chain_rd + r_v[0];
        cr_addr  = r_cnt[2:0];

        case (r_state)
            S_IDLE: begin
                if (accept && i_s_tuser != ModeUnused) begin
                    if (i_s_tuser != ModeFinish) begin
                        push   = 1'b1;
                        push_b = i_s_tdata;
                        n_bcnt = r_bcnt + 1'b1;
                    end
                    n_state = (i_s_tuser == ModeAbsorb) ? S_IDLE : S_PAD80;
                end
            end
            S_PAD80: begin
                push    = 1'b1;
                push_b  = PadByte;
                n_state = S_PADZ;
            end
            S_PADZ: begin
                if (r_fill == LenStart) begin
                    n_state = S_LEN;
                    n_cnt   = '0;
                end else begin
                    push = 1'b1;
                end
            end
            S_LEN: begin
                push   = 1'b1;
                push_b = bit_len[{~r_cnt[2:0], 3'b000} +: 8];
                n_cnt  = r_cnt + 6'd1;
            end
            S_WAIT: begin
                if (!r_ovalid) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                end
            end
            S_LOAD: begin
                // shift chain words in at the tail; prefetch message word 0
                if (r_cnt != 6'd0) begin
                    for (int i = 0; i < ChainWords - 1; i++) n_v[i] = r_v[i + 1];
                    n_v[ChainWords - 1] = chain_rd;
                end
                if (r_cnt == 6'd8) begin
                    n_state = S_ROUND;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ROUND: begin
                mr_addr = r_cnt[3:0] + 4'd1;
                n_v[0] = t1 + t2;
                n_v[1] = r_v[0];
                n_v[2] = r_v[1];
                n_v[3] = r_v[2];
                n_v[4] = r_v[3] + t1;
                n_v[5] = r_v[4];
                n_v[6] = r_v[5];
                n_v[7] = r_v[6];
                for (int i = 0; i < MsgWords - 1; i++) n_w[i] = r_w[i + 1];
                n_w[MsgWords - 1] = w_cur;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = S_WB;
                    n_cnt   = '0;
                end
            end
            S_WB: begin
                if (r_cnt != 6'd0) begin
                    cw_en = 1'b1;
                    for (int i = 0; i < ChainWords - 1; i++) n_v[i] = r_v[i + 1];
                    n_v[ChainWords - 1] = cw_data;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd8) begin
                    n_state = r_ret;
                    n_fresh = r_fin;
                    if (r_fin) begin
                        n_out    = {n_v[6], n_v[7], n_v[4], n_v[5],
                                    n_v[2], n_v[3], n_v[0], n_v[1]};
                        n_ovalid = 1'b1;
                        n_bcnt   = '0;
                        n_fin    = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        mw_data = {r_acc, push_b};
        if (push) begin
            n_acc  = mw_data[23:0];
            mw_en  = (r_fill[1:0] == 2'b11);
            n_fill = r_fill + 6'd1;
            if (r_fill == 6'd63) begin
                n_cnt = '0;
                if (r_state == S_LEN) begin
                    n_ret   = S_IDLE;
                    n_fin   = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    n_ret   = n_state;
                    n_state = S_LOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_bcnt   <= '0;
            r_fin    <= 1'b0;
            r_fresh  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_cnt    <= n_cnt;
            r_fill   <= n_fill;
            r_bcnt   <= n_bcnt;
            r_fin    <= n_fin;
            r_fresh  <= n_fresh;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
        r_v   <= n_v;
        r_w   <= n_w;
    end

    a_round_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_cnt == 6'd63) |=> (r_state == S_WB))
        else $error("last round did not enter write-back");
    a_len_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_fill[5:3] == 3'b111))
        else $error("length bytes outside the block tail");
    a_finish_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser == ModeAbsorbFinish) |=> (r_state == S_PAD80 || r_state == S_LOAD))
        else $error("finish word did not start padding");
    a_wait_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_fin && r_fill == 6'd0))
        else $error("output wait outside the final block");
endmodule

[dv/sha256_stream_hasher_tb.sv]
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256_pkg::*;

    localparam int unsigned CycleLimit = 500000;
    localparam int unsigned RandWords  = 2000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata = '0;   // [7:0] data_byte
    logic [1:0]   i_s_tuser = '0;   // [1:0] mode
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [255:0] o_m_tdata;        // digest_word0, digest_word1, digest_word2, digest_word3

    sha256_stream_hasher u_top (.*);

    always #5 i_clk = ~i_clk;

    // ---- digest predictor ----
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [60:0] msg_len;

    logic [255:0] digest_q [$];
    int unsigned  errors = 0;
    int unsigned  digests_seen = 0;
    int unsigned  words_sent = 0;
    int unsigned  cycle_cnt = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;

    localparam logic [31:0] HashIv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void start_message();
        for (int i = 0; i < 8; i++) hash_state[i] = HashIv[i];
        block_fill = 0;
        msg_len = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                    hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + RoundConst[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill = (block_fill + 1) % 64;
        if (block_fill == 0) compress_block();
    endfunction

    // Apply one accepted word; queue a digest when it closes the message.
    function automatic void hash_word(input logic [7:0] data, input logic [1:0] mode);
        logic [63:0]  bit_len;
        logic [255:0] dig;
        if (mode == ModeUnused) return;
        if (mode != ModeFinish) begin
            absorb_byte(data);
            msg_len = msg_len + 61'd1;
        end
        if (mode == ModeAbsorb) return;
        bit_len = {msg_len, 3'b000};
        absorb_byte(PadByte);
        while (block_fill != LenStart) absorb_byte(8'h00);
        for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
        for (int k = 0; k < 4; k++)
            dig[64*k +: 64] = {hash_state[2*k], hash_state[2*k+1]};
        digest_q.push_back(dig);
        start_message();
    endfunction

    // ---- sender ----
    task automatic send_word(input logic [7:0] data, input logic [1:0] mode);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        hash_word(data, mode);
        words_sent++;
    endtask

    // ---- receiver and checker ----
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            digests_seen++;
            if (digest_q.size() == 0) begin
                $error("digest with none expected: %h", o_m_tdata);
                errors++;
            end else begin
                logic [255:0] want;
                want = digest_q.pop_front();
                for (int k = 0; k < 4; k++)
                    if (o_m_tdata[64*k +: 64] !== want[64*k +: 64]) begin
                        $error("digest_word%0d expected %h got %h", k,
                               want[64*k +: 64], o_m_tdata[64*k +: 64]);
                        errors++;
                    end
            end
        end
    end

    // Directed rows; a digest is typed in only for the empty message.
    typedef struct {
        logic [7:0]   data;
        logic [1:0]   mode;
        bit           fixed;
        logic [255:0] digest;
    } t_row;

    t_row rows [$];

    initial begin
        int unsigned msg_bytes;
        logic [1:0]  close_mode;
        bit          drained;
        drained = 1'b0;
        start_message();
        // empty message
        rows.push_back('{8'hff, ModeFinish, 1'b1,
            {64'ha495991b7852b855, 64'h27ae41e4649b934c,
             64'h9afbf4c8996fb924, 64'he3b0c44298fc1c14}});
        // ignored words around a message, then short messages and an empty one
        rows.push_back('{8'hff, ModeUnused, 1'b0, '0});
        rows.push_back('{8'h61, ModeAbsorb, 1'b0, '0});
        rows.push_back('{8'h00, ModeUnused, 1'b0, '0});
        rows.push_back('{8'h62, ModeAbsorb, 1'b0, '0});
        rows.push_back('{8'h63, ModeAbsorbFinish, 1'b0, '0});
        rows.push_back('{8'hff, ModeAbsorbFinish, 1'b0, '0});
        rows.push_back('{8'h00, ModeAbsorbFinish, 1'b0, '0});
        rows.push_back('{8'h00, ModeAbsorb, 1'b0, '0});
        rows.push_back('{8'hff, ModeAbsorb, 1'b0, '0});
        rows.push_back('{8'h55, ModeFinish, 1'b0, '0});
        rows.push_back('{8'h00, ModeFinish, 1'b0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_word(rows[i].data, rows[i].mode);
            // the typed digest overrides the predicted one
            if (rows[i].fixed) digest_q[digest_q.size()-1] = rows[i].digest;
        end

        // Random messages; lengths cluster near the padding boundaries.
        while (words_sent < RandWords + rows.size()) begin
            case ((words_sent - rows.size()) * 4 / RandWords)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if ($urandom_range(9) < 3) begin
                case ($urandom_range(8))
                    0: msg_bytes = 55;  1: msg_bytes = 56;  2: msg_bytes = 57;
                    3: msg_bytes = 63;  4: msg_bytes = 64;  5: msg_bytes = 65;
                    6: msg_bytes = 119; 7: msg_bytes = 120; default: msg_bytes = 128;
                endcase
            end else begin
                msg_bytes = $urandom_range(70);
            end
            close_mode = (msg_bytes > 0 && $urandom_range(1)) ? ModeAbsorbFinish : ModeFinish;
            for (int n = 0; n < msg_bytes; n++) begin
                if ($urandom_range(19) == 0) send_word(8'($urandom_range(255)), ModeUnused);
                send_word(8'($urandom_range(255)),
                          (n == msg_bytes - 1 && close_mode == ModeAbsorbFinish)
                              ? ModeAbsorbFinish : ModeAbsorb);
            end
            if (close_mode == ModeFinish) send_word(8'($urandom_range(255)), ModeFinish);
            // hold off once until the pipeline drains
            if (words_sent > 1000 && !drained) begin
                drained = 1'b1;
                i_s_tvalid <= 1'b0;
                while (digest_q.size() != 0) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d words (bytes, finishes, ignored words); checked %0d digests",
                 words_sent, digests_seen);
        $display("across no-idle, sender-idle, receiver-stall and mixed phases.");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
